// ===== rtl/mpfp_pkg.sv =====
// Shared types, codes and helpers for the MQTT packet field parser.
`timescale 1ns / 1ps
package mpfp_pkg;

  // Number of fixed CONNECT bytes skipped before the connect flags
  localparam int CONNECT_SKIP_BYTES = 6;

  // Parse phase codes; string phases set bit 5 with kind in [4:2], step in [1:0]
  typedef logic [5:0] phase_t;
  localparam phase_t PH_HDR     = 6'd0;
  localparam phase_t PH_LEN     = 6'd1;
  localparam phase_t PH_CSKIP   = 6'd2;
  localparam phase_t PH_CFLAGS  = 6'd3;
  localparam phase_t PH_KAHI    = 6'd4;
  localparam phase_t PH_KALO    = 6'd5;
  localparam phase_t PH_PIDHI   = 6'd6;
  localparam phase_t PH_PIDLO   = 6'd7;
  localparam phase_t PH_PAYLOAD = 6'd8;
  localparam phase_t PH_QOS     = 6'd9;
  localparam phase_t PH_TRAIL   = 6'd10;
  localparam phase_t PH_DISCARD = 6'd11;

  // String kinds
  localparam logic [2:0] K_CID   = 3'd0;
  localparam logic [2:0] K_WT    = 3'd1;
  localparam logic [2:0] K_WM    = 3'd2;
  localparam logic [2:0] K_USER  = 3'd3;
  localparam logic [2:0] K_PASS  = 3'd4;
  localparam logic [2:0] K_TOPIC = 3'd5;

  // String steps
  localparam logic [1:0] S_LENHI = 2'd0;
  localparam logic [1:0] S_LENLO = 2'd1;
  localparam logic [1:0] S_BODY  = 2'd2;

  // Packet types with a handler
  localparam logic [3:0] T_CONNECT     = 4'd1;
  localparam logic [3:0] T_PUBLISH     = 4'd3;
  localparam logic [3:0] T_PUBACK      = 4'd4;
  localparam logic [3:0] T_PUBREC      = 4'd5;
  localparam logic [3:0] T_PUBREL      = 4'd6;
  localparam logic [3:0] T_PUBCOMP     = 4'd7;
  localparam logic [3:0] T_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] T_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] T_PINGREQ     = 4'd12;
  localparam logic [3:0] T_PINGRESP    = 4'd13;
  localparam logic [3:0] T_DISCONNECT  = 4'd14;

  // Byte roles
  localparam logic [3:0] ROLE_HEADER    = 4'd0;
  localparam logic [3:0] ROLE_LENGTH    = 4'd1;
  localparam logic [3:0] ROLE_SKIPPED   = 4'd2;
  localparam logic [3:0] ROLE_CONNFLAGS = 4'd3;
  localparam logic [3:0] ROLE_KEEPALIVE = 4'd4;
  localparam logic [3:0] ROLE_STRLEN    = 4'd5;
  localparam logic [3:0] ROLE_CLIENTID  = 4'd6;
  localparam logic [3:0] ROLE_PKTID     = 4'd12;
  localparam logic [3:0] ROLE_PAYLOAD   = 4'd13;
  localparam logic [3:0] ROLE_QOS       = 4'd14;
  localparam logic [3:0] ROLE_IGNORED   = 4'd15;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NOHANDLER = 2'd1;
  localparam logic [1:0] ERR_LENGTH    = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  kind;
    logic [3:0]  flags;
    logic [27:0] len_acc;
    logic [1:0]  len_grp;
    logic [27:0] bytes_left;
    logic [7:0]  cflags;
    logic [15:0] fld_left;
    logic [7:0]  hold;
    logic [7:0]  tcnt;
  } state_t;

  // One result item
  typedef struct packed {
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [3:0]  byte_role;
    logic [7:0]  tuple_index;
    logic [27:0] remaining_length;
    logic [15:0] field_value;
    logic        value_done;
    logic        packet_done;
    logic [1:0]  error_code;
  } result_t;

  function automatic phase_t str_phase(input logic [2:0] k, input logic [1:0] s);
    return {1'b1, k, s};
  endfunction

  function automatic logic has_handler(input logic [3:0] t);
    return (t == T_CONNECT) || (t >= T_PUBLISH && t <= T_SUBSCRIBE) ||
           (t == T_UNSUBSCRIBE) || (t >= T_PINGREQ && t <= T_DISCONNECT);
  endfunction

endpackage

// ===== rtl/mqtt_packet_field_parser.sv =====
// Top level: parser state register, per-byte decode and the result register.
// Each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_ready_o is high; the parser state updates in a single pass.
// in_ready_o stays high while the result register is empty or being taken.
// Reset (rst_ni low, asynchronous) returns the parser to the fixed header
// phase with all state cleared and drops out_valid_o.
`timescale 1ns / 1ps
module mqtt_packet_field_parser #(
  parameter int SKIP_BYTES = mpfp_pkg::CONNECT_SKIP_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  packet_type_o,
  output logic [3:0]  header_flags_o,
  output logic [3:0]  byte_role_o,
  output logic [7:0]  tuple_index_o,
  output logic [27:0] remaining_length_o,
  output logic [15:0] field_value_o,
  output logic        value_done_o,
  output logic        packet_done_o,
  output logic [1:0]  error_code_o
);
  import mpfp_pkg::*;

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mpfp_step #(
    .SKIP_BYTES (SKIP_BYTES)
  ) u_step (
    .state_i        (state_q),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // Advance parser state on each accepted item; all-zero state is the header phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign packet_type_o      = res_q.packet_type;
  assign header_flags_o     = res_q.header_flags;
  assign byte_role_o        = res_q.byte_role;
  assign tuple_index_o      = res_q.tuple_index;
  assign remaining_length_o = res_q.remaining_length;
  assign field_value_o      = res_q.field_value;
  assign value_done_o       = res_q.value_done;
  assign packet_done_o      = res_q.packet_done;
  assign error_code_o       = res_q.error_code;

endmodule

// ===== rtl/mpfp_step.sv =====
// Per-byte decode: next parser state and the result item for one byte.
`timescale 1ns / 1ps
module mpfp_step #(
  parameter int SKIP_BYTES = mpfp_pkg::CONNECT_SKIP_BYTES
) (
  input  mpfp_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_start_i,
  output mpfp_pkg::state_t  state_o,
  output mpfp_pkg::result_t result_o
);
  import mpfp_pkg::*;

  typedef struct packed {
    phase_t phase;
    logic   inc;
  } next_t;

  function automatic logic is_sub(input logic [3:0] kind);
    return (kind == T_SUBSCRIBE) || (kind == T_UNSUBSCRIBE);
  endfunction

  function automatic phase_t after_will(input logic [7:0] cf);
    if (cf[7]) return str_phase(K_USER, S_LENHI);
    if (cf[6]) return str_phase(K_PASS, S_LENHI);
    return PH_TRAIL;
  endfunction

  function automatic next_t after_string(input logic [2:0] k, input logic [7:0] cf,
                                         input logic [3:0] kind, input logic [3:0] fl);
    next_t n;
    n.inc   = 1'b0;
    n.phase = PH_TRAIL;
    case (k)
      K_CID:   n.phase = cf[2] ? str_phase(K_WT, S_LENHI) : after_will(cf);
      K_WT:    n.phase = str_phase(K_WM, S_LENHI);
      K_WM:    n.phase = after_will(cf);
      K_USER:  n.phase = cf[6] ? str_phase(K_PASS, S_LENHI) : PH_TRAIL;
      K_TOPIC: begin
        if (kind == T_PUBLISH) begin
          n.phase = (fl[2:1] != 2'b00) ? PH_PIDHI : PH_PAYLOAD;
        end else if (kind == T_SUBSCRIBE) begin
          n.phase = PH_QOS;
        end else if (kind == T_UNSUBSCRIBE) begin
          n.inc   = 1'b1;
          n.phase = str_phase(K_TOPIC, S_LENHI);
        end
      end
      default: n.phase = PH_TRAIL;
    endcase
    return n;
  endfunction

  function automatic phase_t after_pid(input logic [3:0] kind);
    if (kind == T_PUBLISH) return PH_PAYLOAD;
    if (is_sub(kind)) return str_phase(K_TOPIC, S_LENHI);
    return PH_TRAIL;
  endfunction

  function automatic logic end_ok(input phase_t ph, input logic [3:0] kind);
    return (ph == PH_TRAIL) || (ph == PH_PAYLOAD) ||
           ((ph == str_phase(K_TOPIC, S_LENHI)) && is_sub(kind));
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hff) ? c : c + 8'd1;
  endfunction

  state_t      ns;
  result_t     res;
  phase_t      np;
  next_t       an;
  logic [27:0] acc_new;
  logic [27:0] bl_new;
  logic [15:0] word;
  logic [15:0] fl_new;
  logic [2:0]  sk;
  logic [1:0]  ss;

  assign word = {state_i.hold, data_byte_i};
  assign sk   = state_i.phase[4:2];
  assign ss   = state_i.phase[1:0];

  // Merge the next 7-bit length group at its place
  always_comb begin
    case (state_i.len_grp)
      2'd0:    acc_new = state_i.len_acc | {21'd0, data_byte_i[6:0]};
      2'd1:    acc_new = state_i.len_acc | {14'd0, data_byte_i[6:0], 7'd0};
      2'd2:    acc_new = state_i.len_acc | {7'd0, data_byte_i[6:0], 14'd0};
      default: acc_new = state_i.len_acc | {data_byte_i[6:0], 21'd0};
    endcase
  end

  // Decode one byte
  always_comb begin
    ns      = state_i;
    res     = '0;
    res.field_value = {8'd0, data_byte_i};
    np      = PH_TRAIL;
    an      = '0;
    fl_new  = state_i.fld_left;
    bl_new  = (state_i.bytes_left != 28'd0) ? state_i.bytes_left - 28'd1 : 28'd0;

    if (packet_start_i || state_i.phase == PH_HDR) begin
      // Fixed header byte: restart the packet
      ns          = '0;
      ns.kind     = data_byte_i[7:4];
      ns.flags    = data_byte_i[3:0];
      res.byte_role = ROLE_HEADER;
      if (has_handler(data_byte_i[7:4])) begin
        ns.phase = PH_LEN;
      end else begin
        ns.phase       = PH_DISCARD;
        res.error_code = ERR_NOHANDLER;
      end
    end else if (state_i.phase == PH_DISCARD) begin
      res.byte_role = ROLE_IGNORED;
    end else if (state_i.phase == PH_LEN) begin
      res.byte_role = ROLE_LENGTH;
      ns.len_acc    = acc_new;
      if (data_byte_i[7]) begin
        if (state_i.len_grp == 2'd3) begin
          res.error_code = ERR_LENGTH;
          ns.phase       = PH_DISCARD;
        end else begin
          ns.len_grp = state_i.len_grp + 2'd1;
        end
      end else begin
        res.remaining_length = acc_new;
        ns.bytes_left        = acc_new;
        // Pick the first body phase for this type
        case (state_i.kind)
          T_CONNECT: begin
            ns.fld_left = 16'(SKIP_BYTES);
            np = (SKIP_BYTES != 0) ? PH_CSKIP : PH_CFLAGS;
          end
          T_PUBLISH: np = str_phase(K_TOPIC, S_LENHI);
          T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBSCRIBE, T_UNSUBSCRIBE:
            np = PH_PIDHI;
          default:   np = PH_TRAIL;
        endcase
        if (acc_new == 28'd0) begin
          res.packet_done = 1'b1;
          if (!end_ok(np, state_i.kind)) res.error_code = ERR_OVERRUN;
          ns.phase = PH_HDR;
        end else begin
          ns.phase = np;
        end
      end
    end else begin
      // Body byte
      res.remaining_length = state_i.len_acc;
      res.tuple_index      = is_sub(state_i.kind) ? state_i.tcnt : 8'd0;
      ns.bytes_left        = bl_new;
      if (state_i.phase[5]) begin
        if (ss == S_LENHI) begin
          res.byte_role = ROLE_STRLEN;
          ns.hold       = data_byte_i;
          np            = str_phase(sk, S_LENLO);
        end else if (ss == S_LENLO) begin
          res.byte_role   = ROLE_STRLEN;
          res.field_value = word;
          res.value_done  = 1'b1;
          ns.fld_left     = word;
          an = after_string(sk, state_i.cflags, state_i.kind, state_i.flags);
          if (word != 16'd0) begin
            np = str_phase(sk, S_BODY);
          end else begin
            np = an.phase;
            if (an.inc) ns.tcnt = sat_inc(state_i.tcnt);
          end
        end else begin
          res.byte_role = ROLE_CLIENTID + {1'b0, sk};
          if (state_i.fld_left != 16'd0) fl_new = state_i.fld_left - 16'd1;
          ns.fld_left = fl_new;
          an = after_string(sk, state_i.cflags, state_i.kind, state_i.flags);
          if (fl_new != 16'd0) begin
            np = state_i.phase;
          end else begin
            np = an.phase;
            if (an.inc) ns.tcnt = sat_inc(state_i.tcnt);
          end
        end
      end else begin
        case (state_i.phase)
          PH_CSKIP: begin
            res.byte_role = ROLE_SKIPPED;
            if (state_i.fld_left != 16'd0) fl_new = state_i.fld_left - 16'd1;
            ns.fld_left = fl_new;
            np = (fl_new != 16'd0) ? PH_CSKIP : PH_CFLAGS;
          end
          PH_CFLAGS: begin
            res.byte_role  = ROLE_CONNFLAGS;
            res.value_done = 1'b1;
            ns.cflags      = data_byte_i;
            np             = PH_KAHI;
          end
          PH_KAHI: begin
            res.byte_role = ROLE_KEEPALIVE;
            ns.hold       = data_byte_i;
            np            = PH_KALO;
          end
          PH_KALO: begin
            res.byte_role   = ROLE_KEEPALIVE;
            res.field_value = word;
            res.value_done  = 1'b1;
            np              = str_phase(K_CID, S_LENHI);
          end
          PH_PIDHI: begin
            res.byte_role = ROLE_PKTID;
            ns.hold       = data_byte_i;
            np            = PH_PIDLO;
          end
          PH_PIDLO: begin
            res.byte_role   = ROLE_PKTID;
            res.field_value = word;
            res.value_done  = 1'b1;
            np              = after_pid(state_i.kind);
          end
          PH_PAYLOAD: begin
            res.byte_role = ROLE_PAYLOAD;
            np            = PH_PAYLOAD;
          end
          PH_QOS: begin
            res.byte_role  = ROLE_QOS;
            res.value_done = 1'b1;
            ns.tcnt        = sat_inc(state_i.tcnt);
            np             = str_phase(K_TOPIC, S_LENHI);
          end
          default: begin
            res.byte_role = ROLE_SKIPPED;
            np            = PH_TRAIL;
          end
        endcase
      end
      // Close the packet when its length runs out
      if (bl_new == 28'd0) begin
        res.packet_done = 1'b1;
        if (!end_ok(np, state_i.kind)) res.error_code = ERR_OVERRUN;
        ns.phase = PH_HDR;
      end else begin
        ns.phase = np;
      end
    end

    res.packet_type  = ns.kind;
    res.header_flags = ns.flags;
  end

  assign state_o  = ns;
  assign result_o = res;

endmodule
